FILE: rtl/core/rpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg: shared definitions for the ramped pid drive controller
// Field widths, register codes, limits and the structs passed between stages.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // field widths
  localparam int TARGET_W   = 20;
  localparam int GAIN_W     = 10;
  localparam int FLOOR_W    = 7;
  localparam int CEIL_W     = 11;
  localparam int MODE_W     = 2;
  localparam int POS_W      = 21;
  localparam int HEAD_W     = 16;
  localparam int DRIVE_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // internal widths
  localparam int MEAS_W  = 21;
  localparam int SUM_W   = 31;
  localparam int DERIV_W = 21;
  localparam int RAMP_W  = 16;
  localparam int TERM_W  = 17;
  localparam int PROD_P_W = 30;
  localparam int PROD_I_W = 41;
  localparam int PROD_D_W = 31;
  localparam int PROD_H_W = 27;

  // control constants
  localparam int RAMP_STEP           = 5;
  localparam int MIN_POWER_MAGNITUDE = 5;
  localparam int HEAD_WRAP           = 360;
  localparam int DRIVE_MAX           = 4095;
  localparam int DRIVE_MIN           = -4096;

  // mode register bits
  localparam int MODE_TURN_BIT = 0;
  localparam int MODE_RAMP_BIT = 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_TARGET   = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_GAIN_HEADING  = 3'd4,
    REG_FLOOR_POWER   = 3'd5,
    REG_CEILING_POWER = 3'd6,
    REG_MODE          = 3'd7
  } cfg_reg_e;

  // input item kinds
  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // register file contents
  typedef struct packed {
    logic [TARGET_W-1:0] move_target;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [GAIN_W-1:0]   gain_heading;
    logic [FLOOR_W-1:0]  floor_power;
    logic [CEIL_W-1:0]   ceiling_power;
    logic [MODE_W-1:0]   mode;
  } cfg_t;

  // state stage result
  typedef struct packed {
    logic                       zero;
    logic                       done;
    logic [TARGET_W-1:0]        err;
    logic [SUM_W-1:0]           sum;
    logic signed [DERIV_W-1:0]  deriv;
    logic [RAMP_W-1:0]          ramp;
    logic signed [TERM_W-1:0]   term;
  } st_t;

  // product stage result
  typedef struct packed {
    logic                        zero;
    logic                        done;
    logic [PROD_P_W-1:0]         p_prod;
    logic [PROD_I_W-1:0]         i_prod;
    logic signed [PROD_D_W-1:0]  d_prod;
    logic signed [PROD_H_W-1:0]  h_prod;
    logic [RAMP_W-1:0]           ramp;
  } prod_t;

endpackage

FILE: rtl/core/rpd_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd channel interfaces
// Valid/ready channels for control samples and drive results.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic signed [rpd_pkg::POS_W-1:0]  left_position;
  logic signed [rpd_pkg::POS_W-1:0]  right_position;
  logic signed [rpd_pkg::HEAD_W-1:0] heading;

  modport source (output valid, kind, left_position, right_position, heading,
                  input ready);
  modport sink (input valid, kind, left_position, right_position, heading,
                output ready);
endinterface

interface rpd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rpd_pkg::DRIVE_W-1:0] left_drive;
  logic signed [rpd_pkg::DRIVE_W-1:0] right_drive;
  logic                               done_res;

  modport source (output valid, left_drive, right_drive, done_res, input ready);
  modport sink (input valid, left_drive, right_drive, done_res, output ready);
endinterface

FILE: rtl/core/rpd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_cfg: configuration register file
// Write-only registers, loaded by index, reset to their default values.
// ----------------------------------------------------------------------------
module rpd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]      index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0]     data,
  output rpd_pkg::cfg_t                      cfg
);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_target   <= '0;
      cfg.gain_p        <= rpd_pkg::GAIN_W'(61);
      cfg.gain_i        <= '0;
      cfg.gain_d        <= rpd_pkg::GAIN_W'(51);
      cfg.gain_heading  <= '0;
      cfg.floor_power   <= rpd_pkg::FLOOR_W'(5);
      cfg.ceiling_power <= '1;
      cfg.mode          <= rpd_pkg::MODE_W'(2);
    end else if (we) begin
      unique case (rpd_pkg::cfg_reg_e'(index))
        rpd_pkg::REG_MOVE_TARGET:   cfg.move_target   <= data[rpd_pkg::TARGET_W-1:0];
        rpd_pkg::REG_GAIN_P:        cfg.gain_p        <= data[rpd_pkg::GAIN_W-1:0];
        rpd_pkg::REG_GAIN_I:        cfg.gain_i        <= data[rpd_pkg::GAIN_W-1:0];
        rpd_pkg::REG_GAIN_D:        cfg.gain_d        <= data[rpd_pkg::GAIN_W-1:0];
        rpd_pkg::REG_GAIN_HEADING:  cfg.gain_heading  <= data[rpd_pkg::GAIN_W-1:0];
        rpd_pkg::REG_FLOOR_POWER:   cfg.floor_power   <= data[rpd_pkg::FLOOR_W-1:0];
        rpd_pkg::REG_CEILING_POWER: cfg.ceiling_power <= data[rpd_pkg::CEIL_W-1:0];
        rpd_pkg::REG_MODE:          cfg.mode          <= data[rpd_pkg::MODE_W-1:0];
      endcase
    end
  end

endmodule

FILE: rtl/core/rpd_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_state: input register and controller state update
// Forms the measurement, error, saturated integral, difference, ramp cap and
// heading term, and updates the move state once per transaction.
// ----------------------------------------------------------------------------
module rpd_state (
  input  logic          clk,
  input  logic          rst,
  input  rpd_pkg::cfg_t cfg,
  rpd_in_if.sink        in_ch,
  output logic          st_valid,
  input  logic          st_ready,
  output rpd_pkg::st_t  st
);

  // input register
  logic                              s1_valid;
  logic                              s1_kind;
  logic signed [rpd_pkg::POS_W-1:0]  s1_left;
  logic signed [rpd_pkg::POS_W-1:0]  s1_right;
  logic signed [rpd_pkg::HEAD_W-1:0] s1_head;

  // controller state
  logic [rpd_pkg::SUM_W-1:0]    error_sum;
  logic [rpd_pkg::TARGET_W-1:0] last_error;
  logic [rpd_pkg::RAMP_W-1:0]   ramp_cap;
  logic                         finished;

  logic s1_adv;
  logic s1_fire;
  logic is_start;

  logic [rpd_pkg::POS_W-1:0]      abs_l;
  logic [rpd_pkg::POS_W-1:0]      abs_r;
  logic [rpd_pkg::POS_W:0]        dist_sum;
  logic [rpd_pkg::HEAD_W-1:0]     abs_h;
  logic [rpd_pkg::MEAS_W-1:0]     meas;
  logic                           reached;
  logic [rpd_pkg::TARGET_W-1:0]   err;
  logic [rpd_pkg::SUM_W:0]        sum_wide;
  logic [rpd_pkg::SUM_W-1:0]      sum_next;
  logic signed [rpd_pkg::DERIV_W-1:0] deriv;
  logic [rpd_pkg::RAMP_W:0]       ramp_wide;
  logic [rpd_pkg::RAMP_W-1:0]     ramp_next;
  logic signed [rpd_pkg::TERM_W-1:0] head_x;
  logic signed [rpd_pkg::TERM_W-1:0] term;

  // stage handshakes
  assign s1_adv      = !st_valid || st_ready;
  assign s1_fire     = s1_valid && s1_adv;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign is_start    = (s1_kind == rpd_pkg::KIND_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind  <= in_ch.kind;
      s1_left  <= in_ch.left_position;
      s1_right <= in_ch.right_position;
      s1_head  <= in_ch.heading;
    end
  end

  // measurement and target check
  always_comb begin
    abs_l    = s1_left[rpd_pkg::POS_W-1] ? rpd_pkg::POS_W'(-s1_left)
                                         : rpd_pkg::POS_W'(s1_left);
    abs_r    = s1_right[rpd_pkg::POS_W-1] ? rpd_pkg::POS_W'(-s1_right)
                                          : rpd_pkg::POS_W'(s1_right);
    dist_sum = {1'b0, abs_l} + {1'b0, abs_r};
    abs_h    = s1_head[rpd_pkg::HEAD_W-1] ? rpd_pkg::HEAD_W'(-s1_head)
                                          : rpd_pkg::HEAD_W'(s1_head);
    if (cfg.mode[rpd_pkg::MODE_TURN_BIT]) begin
      meas = rpd_pkg::MEAS_W'(abs_h);
    end else begin
      meas = dist_sum[rpd_pkg::POS_W:1];
    end
    reached = finished || ({1'b0, cfg.move_target} <= meas);
    err     = cfg.move_target - meas[rpd_pkg::TARGET_W-1:0];
  end

  // integral with saturation, difference, ramp cap
  always_comb begin
    sum_wide  = {1'b0, error_sum} + (rpd_pkg::SUM_W + 1)'(err);
    sum_next  = sum_wide[rpd_pkg::SUM_W] ? '1 : sum_wide[rpd_pkg::SUM_W-1:0];
    deriv     = signed'({1'b0, err}) - signed'({1'b0, last_error});
    ramp_wide = {1'b0, ramp_cap} + (rpd_pkg::RAMP_W + 1)'(rpd_pkg::RAMP_STEP);
    if (cfg.mode[rpd_pkg::MODE_RAMP_BIT]) begin
      ramp_next = ramp_wide[rpd_pkg::RAMP_W] ? '1 : ramp_wide[rpd_pkg::RAMP_W-1:0];
    end else begin
      ramp_next = ramp_cap;
    end
  end

  // heading term, negative headings wrap by a full turn and are negated
  always_comb begin
    head_x = rpd_pkg::TERM_W'(s1_head);
    if (s1_head[rpd_pkg::HEAD_W-1]) begin
      term = -(head_x + rpd_pkg::TERM_W'(rpd_pkg::HEAD_WRAP));
    end else begin
      term = head_x;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
      ramp_cap   <= '0;
      finished   <= 1'b0;
    end else if (s1_fire) begin
      if (is_start) begin
        error_sum  <= '0;
        last_error <= '0;
        ramp_cap   <= '0;
        finished   <= 1'b0;
      end else if (reached) begin
        finished <= 1'b1;
      end else begin
        error_sum  <= sum_next;
        last_error <= err;
        ramp_cap   <= ramp_next;
      end
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s1_adv) begin
      st_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      st.zero  <= is_start || reached;
      st.done  <= !is_start && reached;
      st.err   <= err;
      st.sum   <= sum_next;
      st.deriv <= deriv;
      st.ramp  <= ramp_next;
      st.term  <= term;
    end
  end

  // checks
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && is_start |=> !finished && error_sum == '0 && ramp_cap == '0)
    else $error("start transaction did not clear move state");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    finished && !(s1_fire && is_start) |=> finished)
    else $error("done state left without a start");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !is_start |=> error_sum >= $past(error_sum))
    else $error("integral decreased on a sample");

  a_err_nonzero: assert property (@(posedge clk) disable iff (rst)
    st_valid && !st.zero |-> st.err != '0)
    else $error("computing result with zero error");

endmodule

FILE: rtl/core/rpd_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_mult: gain products
// Forms the proportional, integral, derivative and heading products in
// parallel and registers them.
// ----------------------------------------------------------------------------
module rpd_mult (
  input  logic          clk,
  input  logic          rst,
  input  rpd_pkg::cfg_t cfg,
  input  logic          st_valid,
  output logic          st_ready,
  input  rpd_pkg::st_t  st,
  output logic          pr_valid,
  input  logic          pr_ready,
  output rpd_pkg::prod_t pr
);

  logic [rpd_pkg::PROD_P_W-1:0]        p_prod;
  logic [rpd_pkg::PROD_I_W-1:0]        i_prod;
  logic signed [rpd_pkg::PROD_D_W-1:0] d_prod;
  logic signed [rpd_pkg::PROD_H_W-1:0] h_prod;

  assign st_ready = !pr_valid || pr_ready;

  // multipliers
  always_comb begin
    p_prod = rpd_pkg::PROD_P_W'(cfg.gain_p) * rpd_pkg::PROD_P_W'(st.err);
    i_prod = rpd_pkg::PROD_I_W'(cfg.gain_i) * rpd_pkg::PROD_I_W'(st.sum);
    d_prod = rpd_pkg::PROD_D_W'(signed'({1'b0, cfg.gain_d}))
           * rpd_pkg::PROD_D_W'(st.deriv);
    h_prod = rpd_pkg::PROD_H_W'(signed'({1'b0, cfg.gain_heading}))
           * rpd_pkg::PROD_H_W'(st.term);
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (st_ready) begin
      pr_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid && st_ready) begin
      pr.zero   <= st.zero;
      pr.done   <= st.done;
      pr.p_prod <= p_prod;
      pr.i_prod <= i_prod;
      pr.d_prod <= d_prod;
      pr.h_prod <= h_prod;
      pr.ramp   <= st.ramp;
    end
  end

endmodule

FILE: rtl/core/rpd_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_shape: power shaping and result register
// Sums pid products, scales by 1/256 toward zero, applies ramp cap (ramp mode),
// minimum substitute, ceiling, heading correction (not turn mode), saturates.
// ----------------------------------------------------------------------------
module rpd_shape (
  input  logic           clk,
  input  logic           rst,
  input  rpd_pkg::cfg_t  cfg,
  input  logic           pr_valid,
  output logic           pr_ready,
  input  rpd_pkg::prod_t pr,
  rpd_out_if.source      out_ch
);

  localparam int RAW_W   = 44;
  localparam int POWER_W = RAW_W - 8;
  localparam int CORR_W  = rpd_pkg::PROD_H_W - 8;
  localparam int CALC_W  = POWER_W + 1;

  logic signed [RAW_W-1:0]    raw;
  logic signed [RAW_W-1:0]    raw_adj;
  logic signed [POWER_W-1:0]  pow0;
  logic signed [POWER_W-1:0]  pow1;
  logic signed [POWER_W-1:0]  pow2;
  logic signed [POWER_W-1:0]  pow3;
  logic signed [POWER_W-1:0]  ramp_s;
  logic signed [POWER_W-1:0]  floor_s;
  logic signed [POWER_W-1:0]  ceil_s;
  logic signed [POWER_W-1:0]  min_s;
  logic signed [rpd_pkg::PROD_H_W-1:0] h_adj;
  logic signed [CORR_W-1:0]   corr;
  logic signed [CALC_W-1:0]   pow_x;
  logic signed [CALC_W-1:0]   corr_x;
  logic signed [CALC_W-1:0]   ldrv;
  logic signed [CALC_W-1:0]   rdrv;

  function automatic logic signed [rpd_pkg::DRIVE_W-1:0] drive_sat(
    input logic signed [CALC_W-1:0] v
  );
    logic signed [rpd_pkg::DRIVE_W-1:0] r;
    if (v > CALC_W'(rpd_pkg::DRIVE_MAX)) begin
      r = rpd_pkg::DRIVE_W'(rpd_pkg::DRIVE_MAX);
    end else if (v < CALC_W'(rpd_pkg::DRIVE_MIN)) begin
      r = rpd_pkg::DRIVE_W'(rpd_pkg::DRIVE_MIN);
    end else begin
      r = rpd_pkg::DRIVE_W'(v);
    end
    return r;
  endfunction

  assign pr_ready = !out_ch.valid || out_ch.ready;

  // pid sum, divide by 256 toward zero
  always_comb begin
    raw = RAW_W'(signed'({1'b0, pr.p_prod})) + RAW_W'(signed'({1'b0, pr.i_prod}))
        + RAW_W'(pr.d_prod);
    raw_adj = raw + (raw[RAW_W-1] ? RAW_W'(255) : RAW_W'(0));
    pow0    = signed'(raw_adj[RAW_W-1:8]);
  end

  // ramp cap, minimum substitute, ceiling
  always_comb begin
    ramp_s  = POWER_W'(pr.ramp);
    floor_s = POWER_W'(cfg.floor_power);
    ceil_s  = POWER_W'(cfg.ceiling_power);
    min_s   = POWER_W'(rpd_pkg::MIN_POWER_MAGNITUDE);
    if (cfg.mode[rpd_pkg::MODE_RAMP_BIT] && (pow0 > ramp_s)) begin
      pow1 = ramp_s;
    end else begin
      pow1 = pow0;
    end
    if ((pow1 < min_s) && (pow1 > -min_s)) begin
      pow2 = floor_s;
    end else begin
      pow2 = pow1;
    end
    pow3 = (pow2 > ceil_s) ? ceil_s : pow2;
  end

  // heading correction and wheel split
  always_comb begin
    h_adj  = pr.h_prod + (pr.h_prod[rpd_pkg::PROD_H_W-1] ? rpd_pkg::PROD_H_W'(255)
                                                        : rpd_pkg::PROD_H_W'(0));
    corr   = signed'(h_adj[rpd_pkg::PROD_H_W-1:8]);
    pow_x  = CALC_W'(pow3);
    corr_x = CALC_W'(corr);
    if (cfg.mode[rpd_pkg::MODE_TURN_BIT]) begin
      ldrv = pow_x;
      rdrv = -pow_x;
    end else begin
      ldrv = pow_x - corr_x;
      rdrv = pow_x + corr_x;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pr_ready) begin
      out_ch.valid <= pr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_valid && pr_ready) begin
      out_ch.done_res <= pr.done;
      if (pr.zero) begin
        out_ch.left_drive  <= '0;
        out_ch.right_drive <= '0;
      end else begin
        out_ch.left_drive  <= drive_sat(ldrv);
        out_ch.right_drive <= drive_sat(rdrv);
      end
    end
  end

  // checks
  a_done_zero_drive: assert property (@(posedge clk) disable iff (rst)
    pr_valid && pr_ready && pr.done |=>
      out_ch.valid && out_ch.done_res && out_ch.left_drive == '0
      && out_ch.right_drive == '0)
    else $error("done result carries drive");

endmodule

FILE: rtl/core/ramped_pid_drive_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_pid_drive_controller_core: pid drive controller with slew limit
// Start and sample transactions in, one drive result out per transaction.
//
//   channel   role    handshake        payload
//   in_ch     sink    valid / ready    kind, left_position, right_position,
//                                      heading
//   out_ch    source  valid / ready    left_drive, right_drive, done_res
//   cfg       write   cfg_we           cfg_index, cfg_data
//
// One transaction per cycle unless out_ch stalls; the state update (measurement,
// error, saturating integral) is written as the item enters the state stage.
// Reset loads the register defaults and clears state and all stage valids.
// Each stage holds its item while the next is full; in_ch.ready falls only
// when all four stage registers hold items and out_ch is stalled.
// ----------------------------------------------------------------------------
module ramped_pid_drive_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data,
  rpd_in_if.sink                         in_ch,
  rpd_out_if.source                      out_ch
);

  rpd_pkg::cfg_t  cfg;
  rpd_pkg::st_t   st;
  rpd_pkg::prod_t pr;
  logic           st_valid;
  logic           st_ready;
  logic           pr_valid;
  logic           pr_ready;

  // configuration registers
  rpd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // input register and state update
  rpd_state u_state (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st       (st)
  );

  // gain products
  rpd_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st       (st),
    .pr_valid (pr_valid),
    .pr_ready (pr_ready),
    .pr       (pr)
  );

  // shaping and result register
  rpd_shape u_shape (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pr_valid (pr_valid),
    .pr_ready (pr_ready),
    .pr       (pr),
    .out_ch   (out_ch)
  );

endmodule
